// ===== rtl/stop_and_wait_exchange_engine_top_defines.svh =====
// Assertion macros for the stop-and-wait exchange engine.
// Used by rtl modules that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef STOP_AND_WAIT_EXCHANGE_ENGINE_TOP_DEFINES_SVH
`define STOP_AND_WAIT_EXCHANGE_ENGINE_TOP_DEFINES_SVH

// check while out of reset
`define SWE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check on every edge, reset included
`define SWE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/swe_pkg.sv =====
// Shared types and constants of the stop-and-wait exchange engine.
// No dependencies; imported by the interfaces and all rtl modules.
package swe_pkg;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_PACKET = 2'd2,
    OP_TICK   = 2'd3
  } swe_op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_ACKW = 2'd1,
    ST_ANSW = 2'd2,
    ST_FAIL = 2'd3
  } swe_state_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } swe_kind_e;

  typedef enum logic [1:0] {
    CFG_PEER_ADDRESS   = 2'd0,
    CFG_PEER_PORT      = 2'd1,
    CFG_RETRY_INTERVAL = 2'd2,
    CFG_RETRY_LIMIT    = 2'd3
  } swe_cfg_idx_e;

  localparam logic [7:0]  AckByte      = 8'hAC;
  localparam logic [7:0]  DataByte     = 8'h44;
  localparam logic [7:0]  AnswerByte   = 8'h41;
  localparam logic [7:0]  CrcBytes     = 8'd2;
  localparam logic [10:0] AckLength    = 11'd2;
  localparam logic [10:0] AnswerLength = 11'd3;
  localparam logic [7:0]  SeqMax       = 8'hFF;

  localparam logic [31:0] RstPeerAddress   = 32'd0;
  localparam logic [15:0] RstPeerPort      = 16'd22596;
  localparam logic [7:0]  RstRetryInterval = 8'd2;
  localparam logic [7:0]  RstRetryLimit    = 8'd5;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  read_length;
    logic [31:0] src_address;
    logic [15:0] src_udp_port;
    logic [7:0]  pkt_type;
    logic [7:0]  pkt_seq;
    logic [7:0]  pkt_third;
    logic [10:0] pkt_length;
    logic        crc_ok;
  } swe_item_t;

  typedef struct packed {
    logic       send_request;
    logic       request_kind;
    logic [7:0] request_seq;
    logic [7:0] request_length;
    logic       send_ack;
    logic [7:0] ack_seq;
    logic [1:0] status;
    logic       done_res;
    logic       dropped;
  } swe_result_t;

endpackage

// ===== rtl/swe_in_if.sv =====
// Input item channel: valid/ready handshake plus one item's fields.
// Depends on swe_pkg.
interface swe_in_if;
  import swe_pkg::*;

  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  read_length;
  logic [31:0] src_address;
  logic [15:0] src_udp_port;
  logic [7:0]  pkt_type;
  logic [7:0]  pkt_seq;
  logic [7:0]  pkt_third;
  logic [10:0] pkt_length;
  logic        crc_ok;

  modport source (
    output valid, op, read_length, src_address, src_udp_port, pkt_type, pkt_seq,
           pkt_third, pkt_length, crc_ok,
    input  ready
  );
  modport sink (
    input  valid, op, read_length, src_address, src_udp_port, pkt_type, pkt_seq,
           pkt_third, pkt_length, crc_ok,
    output ready
  );
endinterface

// ===== rtl/swe_out_if.sv =====
// Result channel: valid/ready handshake plus one result's fields.
// Depends on swe_pkg.
interface swe_out_if;
  import swe_pkg::*;

  logic       valid;
  logic       ready;
  logic       send_request;
  logic       request_kind;
  logic [7:0] request_seq;
  logic [7:0] request_length;
  logic       send_ack;
  logic [7:0] ack_seq;
  logic [1:0] status;
  logic       done_res;
  logic       dropped;

  modport source (
    output valid, send_request, request_kind, request_seq, request_length,
           send_ack, ack_seq, status, done_res, dropped,
    input  ready
  );
  modport sink (
    input  valid, send_request, request_kind, request_seq, request_length,
           send_ack, ack_seq, status, done_res, dropped,
    output ready
  );
endinterface

// ===== rtl/swe_cfg_if.sv =====
// Configuration write channel: valid/ready, register index and write data.
// Depends on swe_pkg.
interface swe_cfg_if;
  import swe_pkg::*;

  logic         valid;
  logic         ready;
  swe_cfg_idx_e index;
  logic [31:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/swe_in_reg.sv =====
// Input register stage: captures one beat from the input channel.
// Depends on swe_pkg and swe_in_if.
module swe_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  swe_in_if.sink              in_i,
  input  logic                advance_i,
  output logic                valid_o,
  output swe_pkg::swe_item_t  item_o
);
  import swe_pkg::*;

  logic      valid_q;
  swe_item_t item_q;
  logic      take;

  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= '{op: in_i.op, read_length: in_i.read_length,
                  src_address: in_i.src_address, src_udp_port: in_i.src_udp_port,
                  pkt_type: in_i.pkt_type, pkt_seq: in_i.pkt_seq,
                  pkt_third: in_i.pkt_third, pkt_length: in_i.pkt_length,
                  crc_ok: in_i.crc_ok};
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

// ===== rtl/swe_core.sv =====
// Exchange state, configuration registers and the per-item update logic.
// Depends on swe_pkg, swe_cfg_if and the assertion macro header.
`include "stop_and_wait_exchange_engine_top_defines.svh"

module swe_core #(
  parameter int unsigned RX_BUFFER_BYTES = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  swe_cfg_if.sink              cfg_i,
  input  logic                 advance_i,
  input  swe_pkg::swe_item_t   item_i,
  output swe_pkg::swe_result_t res_o
);
  import swe_pkg::*;

  localparam logic [10:0] MaxReadLength = 11'(RX_BUFFER_BYTES + 2);

  logic [31:0] peer_addr_q;
  logic [15:0] peer_port_q;
  logic [7:0]  interval_q;
  logic [7:0]  limit_q;

  swe_state_e st_q, st_d;
  swe_kind_e  kind_q, kind_d;
  logic [7:0] seq_q, seq_d;
  logic [7:0] acked_q, acked_d;
  logic [7:0] retry_q, retry_d;
  logic [7:0] cd_q, cd_d;
  logic [7:0] rlen_q, rlen_d;

  logic        src_ok;
  logic        is_rd;
  logic        good;
  logic [7:0]  cd_dec;
  logic [7:0]  seq_inc;
  swe_result_t res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peer_addr_q <= RstPeerAddress;
      peer_port_q <= RstPeerPort;
      interval_q  <= RstRetryInterval;
      limit_q     <= RstRetryLimit;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_PEER_ADDRESS:   peer_addr_q <= cfg_i.data;
        CFG_PEER_PORT:      peer_port_q <= cfg_i.data[15:0];
        CFG_RETRY_INTERVAL: interval_q  <= cfg_i.data[7:0];
        CFG_RETRY_LIMIT:    limit_q     <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      kind_q  <= KIND_NONE;
      seq_q   <= '0;
      acked_q <= '0;
      retry_q <= '0;
      cd_q    <= '0;
      rlen_q  <= '0;
    end else if (advance_i) begin
      st_q    <= st_d;
      kind_q  <= kind_d;
      seq_q   <= seq_d;
      acked_q <= acked_d;
      retry_q <= retry_d;
      cd_q    <= cd_d;
      rlen_q  <= rlen_d;
    end
  end

  always_comb begin
    st_d    = st_q;
    kind_d  = kind_q;
    seq_d   = seq_q;
    acked_d = acked_q;
    retry_d = retry_q;
    cd_d    = cd_q;
    rlen_d  = rlen_q;
    res     = '0;
    cd_dec  = (cd_q != 8'd0) ? cd_q - 8'd1 : cd_q;
    seq_inc = seq_q + 8'd1;
    src_ok  = (item_i.src_address == peer_addr_q) && (item_i.src_udp_port == peer_port_q);
    is_rd   = (kind_q == KIND_READ);
    good    = is_rd ? (item_i.pkt_type == DataByte && item_i.pkt_length >= AnswerLength
                       && item_i.crc_ok)
                    : (item_i.pkt_type == DataByte && item_i.pkt_third == AnswerByte
                       && item_i.pkt_length == AnswerLength);

    unique case (swe_op_e'(item_i.op))
      OP_WRITE, OP_READ: begin
        kind_d  = (item_i.op == OP_READ) ? KIND_READ : KIND_WRITE;
        rlen_d  = (item_i.op == OP_READ) ? item_i.read_length : 8'd0;
        st_d    = ST_ACKW;
        retry_d = '0;
        cd_d    = interval_q;
        res.send_request   = 1'b1;
        res.request_kind   = (item_i.op == OP_READ);
        res.request_seq    = seq_q;
        res.request_length = (item_i.op == OP_READ) ? item_i.read_length + CrcBytes : 8'd0;
      end
      OP_TICK: begin
        if (st_q == ST_ACKW) begin
          cd_d = cd_dec;
          if (cd_dec == 8'd0) begin
            res.send_request   = 1'b1;
            res.request_kind   = is_rd;
            res.request_seq    = seq_q;
            res.request_length = is_rd ? rlen_q + CrcBytes : 8'd0;
            retry_d = (retry_q != SeqMax) ? retry_q + 8'd1 : retry_q;
            cd_d    = interval_q;
          end
          if (retry_d >= limit_q) begin
            st_d   = ST_FAIL;
            kind_d = KIND_NONE;
          end
        end
      end
      OP_PACKET: begin
        if (!src_ok) begin
          res.dropped = 1'b1;
        end else if (kind_q == KIND_WRITE || kind_q == KIND_READ) begin
          if (is_rd && item_i.pkt_length > MaxReadLength) begin
            res.dropped = 1'b1;
          end else if (st_q == ST_ACKW) begin
            if (item_i.pkt_type == AckByte && item_i.pkt_seq == seq_q
                && item_i.pkt_length == AckLength) begin
              seq_d   = (seq_inc == 8'd0) ? 8'd1 : seq_inc;
              retry_d = '0;
              cd_d    = interval_q;
              st_d    = ST_ANSW;
            end else begin
              res.send_ack = 1'b1;
              res.ack_seq  = item_i.pkt_seq;
            end
          end else if (st_q == ST_ANSW) begin
            if (good) begin
              res.send_ack = 1'b1;
              res.ack_seq  = item_i.pkt_seq;
              res.done_res = 1'b1;
              acked_d      = item_i.pkt_seq;
              st_d         = ST_IDLE;
              kind_d       = KIND_NONE;
            end
          end else if (st_q == ST_IDLE) begin
            res.send_ack = 1'b1;
            res.ack_seq  = item_i.pkt_seq;
            acked_d      = item_i.pkt_seq;
          end
        end else if (kind_q == KIND_NONE) begin
          if (acked_q == item_i.pkt_seq && item_i.pkt_type == DataByte) begin
            res.send_ack = 1'b1;
            res.ack_seq  = item_i.pkt_seq;
          end
        end
      end
      default: ;
    endcase

    res.status = st_d;
  end

  assign res_o = res;

  `SWE_ASSERT(a_fail_clears_kind, (st_q == ST_FAIL) |-> (kind_q == KIND_NONE), "failed state with a kind pending")
  `SWE_ASSERT(a_busy_has_kind, (st_q == ST_ACKW || st_q == ST_ANSW) |-> (kind_q != KIND_NONE), "exchange busy without a kind")
  `SWE_ASSERT(a_seq_skips_zero, (seq_q != $past(seq_q)) |-> (seq_q != 8'd0), "sequence advanced to zero")
  `SWE_ASSERT(a_done_acks, (advance_i && res.done_res) |-> (res.send_ack && res.status == ST_IDLE), "completion without ack or idle")
  `SWE_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> (st_q == ST_IDLE || rst_ni), "state not idle in reset")
endmodule

// ===== rtl/swe_out_reg.sv =====
// Result register: holds one result beat until the output channel takes it.
// Depends on swe_pkg and swe_out_if.
module swe_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  swe_pkg::swe_result_t res_i,
  output logic                 ready_o,
  swe_out_if.source            out_o
);
  import swe_pkg::*;

  logic        valid_q;
  swe_result_t res_q;

  assign ready_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ready_o) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.send_request   = res_q.send_request;
  assign out_o.request_kind   = res_q.request_kind;
  assign out_o.request_seq    = res_q.request_seq;
  assign out_o.request_length = res_q.request_length;
  assign out_o.send_ack       = res_q.send_ack;
  assign out_o.ack_seq        = res_q.ack_seq;
  assign out_o.status         = res_q.status;
  assign out_o.done_res       = res_q.done_res;
  assign out_o.dropped        = res_q.dropped;
endmodule

// ===== rtl/stop_and_wait_exchange_engine_top.sv =====
// Stop-and-wait exchange engine top: input register, exchange core, result register.
// Each accepted item is registered in the input register, its result in the result register.
// Throughput: one item per cycle unless output stalls; the core updates state once per item.
// Output stalls hold the input register, so no beat is lost or repeated.
// Reset clears the exchange state and loads the configuration reset values.
// Depends on swe_pkg, swe_in_if, swe_out_if, swe_cfg_if, swe_in_reg, swe_core, swe_out_reg.
module stop_and_wait_exchange_engine_top #(
  parameter int unsigned RX_BUFFER_BYTES = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  swe_in_if.sink    in_i,
  swe_out_if.source res_o,
  swe_cfg_if.sink   cfg_i
);
  import swe_pkg::*;

  logic        item_valid;
  swe_item_t   item;
  swe_result_t res;
  logic        out_ready;
  logic        advance;

  assign advance = item_valid && out_ready;

  swe_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .valid_o   (item_valid),
    .item_o    (item)
  );

  swe_core #(
    .RX_BUFFER_BYTES (RX_BUFFER_BYTES)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_i),
    .advance_i (advance),
    .item_i    (item),
    .res_o     (res)
  );

  swe_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (item_valid),
    .res_i   (res),
    .ready_o (out_ready),
    .out_o   (res_o)
  );
endmodule

// ===== sim/stop_and_wait_exchange_engine_top_test.sv =====
// Self-checking bench for stop_and_wait_exchange_engine_top: directed and random exchanges.
// A scoreboard class predicts each result beat; depends on swe_pkg and the three rtl interfaces.
// Random gaps on both handshakes; config is rewritten between phases once the block is drained.
module stop_and_wait_exchange_engine_top_test;
  import swe_pkg::*;

  localparam int RxBufferBytes = 256;
  localparam int WatchdogLimit = 1000;
  localparam int DrainCycles   = 4;
  localparam int RandomItems   = 1200;

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   calm;
  int   idle_cycles;
  int   items_sent;

  swe_in_if  in_bus();
  swe_out_if res_bus();
  swe_cfg_if cfg_bus();

  stop_and_wait_exchange_engine_top #(
    .RX_BUFFER_BYTES(RxBufferBytes)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .res_o (res_bus),
    .cfg_i (cfg_bus)
  );

  class exchange_tracker;
    logic [31:0] peer_address;
    logic [15:0] peer_port;
    logic [7:0]  retry_interval;
    logic [7:0]  retry_limit;
    swe_state_e  state;
    swe_kind_e   kind;
    logic [7:0]  seq;
    logic [7:0]  last_acked;
    logic [7:0]  retry_count;
    logic [7:0]  countdown;
    logic [7:0]  read_len;
    swe_result_t expected_q[$];
    int          mismatches;

    function new();
      peer_address   = RstPeerAddress;
      peer_port      = RstPeerPort;
      retry_interval = RstRetryInterval;
      retry_limit    = RstRetryLimit;
      state          = ST_IDLE;
      kind           = KIND_NONE;
      seq            = 8'd0;
      last_acked     = 8'd0;
      retry_count    = 8'd0;
      countdown      = 8'd0;
      read_len       = 8'd0;
      mismatches     = 0;
    endfunction

    function void write_reg(swe_cfg_idx_e idx, logic [31:0] value);
      case (idx)
        CFG_PEER_ADDRESS:   peer_address = value;
        CFG_PEER_PORT:      peer_port = value[15:0];
        CFG_RETRY_INTERVAL: retry_interval = value[7:0];
        CFG_RETRY_LIMIT:    retry_limit = value[7:0];
        default: ;
      endcase
    endfunction

    function swe_result_t add_request(swe_result_t r);
      r.send_request   = 1'b1;
      r.request_kind   = (kind == KIND_READ);
      r.request_seq    = seq;
      r.request_length = (kind == KIND_READ) ? read_len + CrcBytes : 8'd0;
      return r;
    endfunction

    function swe_result_t add_ack(swe_result_t r, logic [7:0] s);
      r.send_ack = 1'b1;
      r.ack_seq  = s;
      return r;
    endfunction

    function void note_item(swe_item_t it);
      swe_result_t r;
      logic        rd;
      logic        good;
      r = '0;
      case (it.op)
        OP_WRITE, OP_READ: begin
          kind        = (it.op == OP_WRITE) ? KIND_WRITE : KIND_READ;
          read_len    = (it.op == OP_READ) ? it.read_length : 8'd0;
          state       = ST_ACKW;
          retry_count = 8'd0;
          countdown   = retry_interval;
          r           = add_request(r);
        end
        OP_TICK: begin
          if (state == ST_ACKW) begin
            if (countdown > 8'd0) countdown = countdown - 8'd1;
            if (countdown == 8'd0) begin
              r = add_request(r);
              if (retry_count < SeqMax) retry_count = retry_count + 8'd1;
              countdown = retry_interval;
            end
            if (retry_count >= retry_limit) begin
              state = ST_FAIL;
              kind  = KIND_NONE;
            end
          end
        end
        default: begin
          rd = (kind == KIND_READ);
          if (it.src_address != peer_address || it.src_udp_port != peer_port) begin
            r.dropped = 1'b1;
          end else if (kind == KIND_WRITE || kind == KIND_READ) begin
            if (rd && int'(it.pkt_length) > RxBufferBytes + 2) begin
              r.dropped = 1'b1;
            end else if (state == ST_ACKW) begin
              if (it.pkt_type == AckByte && it.pkt_seq == seq && it.pkt_length == AckLength) begin
                seq = seq + 8'd1;
                if (seq == 8'd0) seq = 8'd1;
                retry_count = 8'd0;
                countdown   = retry_interval;
                state       = ST_ANSW;
              end else begin
                r = add_ack(r, it.pkt_seq);
              end
            end else if (state == ST_ANSW) begin
              if (rd) begin
                good = (it.pkt_type == DataByte) && (it.pkt_length >= AnswerLength) && it.crc_ok;
              end else begin
                good = (it.pkt_type == DataByte) && (it.pkt_third == AnswerByte) &&
                       (it.pkt_length == AnswerLength);
              end
              if (good) begin
                r          = add_ack(r, it.pkt_seq);
                last_acked = it.pkt_seq;
                state      = ST_IDLE;
                kind       = KIND_NONE;
                r.done_res = 1'b1;
              end
            end else if (state == ST_IDLE) begin
              r          = add_ack(r, it.pkt_seq);
              last_acked = it.pkt_seq;
            end
          end else if (kind == KIND_NONE) begin
            if (last_acked == it.pkt_seq && it.pkt_type == DataByte) r = add_ack(r, it.pkt_seq);
          end
        end
      endcase
      r.status = state;
      expected_q.push_back(r);
    endfunction

    function string show(swe_result_t r);
      return $sformatf("req=%0b kind=%0b rseq=%02h rlen=%02h ack=%0b aseq=%02h st=%0d done=%0b drop=%0b",
                       r.send_request, r.request_kind, r.request_seq, r.request_length,
                       r.send_ack, r.ack_seq, r.status, r.done_res, r.dropped);
    endfunction

    function void check_result(swe_result_t got);
      swe_result_t want;
      if (expected_q.size() == 0) begin
        if (mismatches < 10) $display("unexpected result beat: %s", show(got));
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          if (mismatches < 10) begin
            $display("result mismatch\n  expected %s\n  actual   %s", show(want), show(got));
          end
          mismatches++;
        end
      end
    endfunction
  endclass

  exchange_tracker tracker;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic swe_item_t any_item();
    swe_item_t it;
    it.op           = 2'($urandom_range(0, 3));
    it.read_length  = 8'($urandom);
    it.src_address  = $urandom;
    it.src_udp_port = 16'($urandom);
    it.pkt_type     = 8'($urandom);
    it.pkt_seq      = 8'($urandom);
    it.pkt_third    = 8'($urandom);
    it.pkt_length   = 11'($urandom_range(0, 1500));
    it.crc_ok       = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic swe_item_t from_peer(logic [7:0] ptype, logic [7:0] pseq,
                                          logic [7:0] third, logic [10:0] plen, logic crc);
    swe_item_t it;
    it              = any_item();
    it.op           = OP_PACKET;
    it.src_address  = tracker.peer_address;
    it.src_udp_port = tracker.peer_port;
    it.pkt_type     = ptype;
    it.pkt_seq      = pseq;
    it.pkt_third    = third;
    it.pkt_length   = plen;
    it.crc_ok       = crc;
    return it;
  endfunction

  task automatic send(swe_item_t it);
    int gap;
    in_bus.valid        <= 1'b1;
    in_bus.op           <= it.op;
    in_bus.read_length  <= it.read_length;
    in_bus.src_address  <= it.src_address;
    in_bus.src_udp_port <= it.src_udp_port;
    in_bus.pkt_type     <= it.pkt_type;
    in_bus.pkt_seq      <= it.pkt_seq;
    in_bus.pkt_third    <= it.pkt_third;
    in_bus.pkt_length   <= it.pkt_length;
    in_bus.crc_ok       <= it.crc_ok;
    do @(posedge clk_i); while (!in_bus.ready);
    tracker.note_item(it);
    items_sent++;
    gap = gap_len();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic start_op(swe_op_e op, logic [7:0] len);
    swe_item_t it;
    it             = any_item();
    it.op          = op;
    it.read_length = len;
    send(it);
  endtask

  task automatic tick();
    swe_item_t it;
    it    = any_item();
    it.op = OP_TICK;
    send(it);
  endtask

  task automatic peer_pkt(logic [7:0] ptype, logic [7:0] pseq, logic [7:0] third,
                          logic [10:0] plen, logic crc);
    send(from_peer(ptype, pseq, third, plen, crc));
  endtask

  task automatic noise();
    swe_item_t it;
    it = any_item();
    if ($urandom_range(0, 1) == 0) begin
      it.src_address  = tracker.peer_address;
      it.src_udp_port = tracker.peer_port;
    end
    send(it);
  endtask

  task automatic write_reg(swe_cfg_idx_e idx, logic [31:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    tracker.write_reg(idx, value);
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (tracker.expected_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic exchange();
    logic        rd;
    int          r;
    int          ticks;
    int          cap;
    logic [10:0] plen;
    logic [7:0]  third;
    rd = 1'($urandom_range(0, 1));
    start_op(rd ? OP_READ : OP_WRITE, 8'($urandom));
    cap = (tracker.retry_interval == 8'd0) ? 1 : int'(tracker.retry_interval);
    cap = cap * (int'(tracker.retry_limit) + 1) + 1;
    if (cap > 300) cap = 300;
    r = $urandom_range(0, 99);
    if (r < 65) ticks = $urandom_range(0, 1);
    else if (r < 97) ticks = $urandom_range(0, int'(tracker.retry_interval) + 1);
    else ticks = $urandom_range(0, cap);
    for (int i = 0; i < ticks; i++) begin
      if ($urandom_range(0, 9) == 0) noise();
      tick();
    end
    if ($urandom_range(0, 9) == 0) begin
      peer_pkt(AckByte, tracker.seq + 8'($urandom_range(0, 1)), 8'($urandom),
               11'($urandom_range(1, 3)), 1'($urandom_range(0, 1)));
    end
    if ($urandom_range(0, 19) != 0) begin
      peer_pkt(AckByte, tracker.seq, 8'($urandom), AckLength, 1'($urandom_range(0, 1)));
    end
    if ($urandom_range(0, 9) == 0) noise();
    if (rd) begin
      plen = ($urandom_range(0, 9) < 8) ? 11'($urandom_range(3, 40))
                                        : 11'($urandom_range(0, RxBufferBytes + 4));
      peer_pkt(DataByte, 8'($urandom), 8'($urandom), plen, 1'($urandom_range(0, 9) != 0));
    end else begin
      third = ($urandom_range(0, 9) != 0) ? AnswerByte : 8'($urandom);
      plen  = ($urandom_range(0, 9) != 0) ? AnswerLength : 11'($urandom_range(0, 1500));
      peer_pkt(DataByte, 8'($urandom), third, plen, 1'($urandom_range(0, 1)));
    end
    if ($urandom_range(0, 4) == 0) begin
      peer_pkt(DataByte, tracker.last_acked, 8'($urandom), 11'($urandom_range(0, 1500)),
               1'($urandom_range(0, 1)));
    end
  endtask

  task automatic random_phase();
    int target;
    int r;
    r = $urandom_range(0, 3);
    write_reg(CFG_PEER_ADDRESS, (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : $urandom);
    r = $urandom_range(0, 4);
    write_reg(CFG_PEER_PORT, (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF :
                             (r == 2) ? 32'(RstPeerPort) : 32'($urandom_range(0, 65535)));
    r = $urandom_range(0, 5);
    write_reg(CFG_RETRY_INTERVAL, (r == 0) ? 32'd1 : (r == 1) ? 32'd255 :
                                  (r == 2) ? 32'd0 : 32'($urandom_range(1, 8)));
    r = $urandom_range(0, 5);
    write_reg(CFG_RETRY_LIMIT, (r == 0) ? 32'd1 : (r == 1) ? 32'd255 :
                               (r == 2) ? 32'd0 : 32'($urandom_range(1, 8)));
    calm   = ($urandom_range(0, 3) == 0);
    target = items_sent + $urandom_range(80, 200);
    while (items_sent < target) begin
      if ($urandom_range(0, 4) == 0) noise();
      else exchange();
    end
    drain();
  endtask

  initial begin : result_ready
    int gap;
    res_bus.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      gap = gap_len();
      if (gap > 0) begin
        res_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : watch
    swe_result_t got;
    if (rst_ni) begin
      if (res_bus.valid && res_bus.ready) begin
        got.send_request   = res_bus.send_request;
        got.request_kind   = res_bus.request_kind;
        got.request_seq    = res_bus.request_seq;
        got.request_length = res_bus.request_length;
        got.send_ack       = res_bus.send_ack;
        got.ack_seq        = res_bus.ack_seq;
        got.status         = res_bus.status;
        got.done_res       = res_bus.done_res;
        got.dropped        = res_bus.dropped;
        tracker.check_result(got);
      end
      if ((in_bus.valid && in_bus.ready) || (res_bus.valid && res_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    swe_item_t it;
    tracker     = new();
    idle_cycles = 0;
    items_sent  = 0;
    calm        = 1'b0;
    rst_ni              <= 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.op           <= OP_TICK;
    in_bus.read_length  <= 8'd0;
    in_bus.src_address  <= 32'd0;
    in_bus.src_udp_port <= 16'd0;
    in_bus.pkt_type     <= 8'd0;
    in_bus.pkt_seq      <= 8'd0;
    in_bus.pkt_third    <= 8'd0;
    in_bus.pkt_length   <= 11'd0;
    in_bus.crc_ok       <= 1'b0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= CFG_PEER_ADDRESS;
    cfg_bus.data        <= 32'd0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: stray data, source filter, idle tick
    peer_pkt(DataByte, 8'd0, 8'($urandom), AnswerLength, 1'b1);
    peer_pkt(DataByte, 8'h33, 8'($urandom), AnswerLength, 1'b1);
    it = from_peer(DataByte, 8'd0, 8'd0, AnswerLength, 1'b1);
    it.src_address = 32'hFFFF_FFFF;
    send(it);
    it = from_peer(DataByte, 8'd0, 8'd0, AnswerLength, 1'b1);
    it.src_udp_port = 16'd0;
    send(it);
    tick();

    // write exchange with a retransmission and bad acks
    start_op(OP_WRITE, 8'hFF);
    tick();
    tick();
    peer_pkt(DataByte, 8'h77, 8'd0, AnswerLength, 1'b0);
    peer_pkt(AckByte, tracker.seq, 8'd0, AnswerLength, 1'b1);
    peer_pkt(AckByte, tracker.seq, 8'd0, AckLength, 1'b1);
    peer_pkt(DataByte, 8'h5A, 8'h42, AnswerLength, 1'b1);
    peer_pkt(DataByte, 8'h5A, AnswerByte, AnswerLength, 1'b0);
    peer_pkt(DataByte, 8'h5A, 8'd0, 11'd0, 1'b0);

    // read exchange: oversize, bad crc, largest buffer
    start_op(OP_READ, 8'hFF);
    peer_pkt(AckByte, tracker.seq, 8'd0, 11'(RxBufferBytes + 3), 1'b1);
    peer_pkt(DataByte, 8'd0, 8'd0, 11'd1500, 1'b1);
    peer_pkt(AckByte, tracker.seq, 8'd0, AckLength, 1'b1);
    peer_pkt(DataByte, 8'hFF, 8'hFF, 11'(RxBufferBytes + 2), 1'b0);
    peer_pkt(DataByte, 8'hFF, 8'hFF, 11'(RxBufferBytes + 2), 1'b1);
    start_op(OP_READ, 8'd0);
    start_op(OP_WRITE, 8'd0);
    drain();

    // zero retry registers: retransmit and fail on the first tick
    write_reg(CFG_PEER_ADDRESS, 32'hFFFF_FFFF);
    write_reg(CFG_PEER_PORT, 32'hFFFF);
    write_reg(CFG_RETRY_INTERVAL, 32'd0);
    write_reg(CFG_RETRY_LIMIT, 32'd0);
    start_op(OP_WRITE, 8'h80);
    tick();
    peer_pkt(DataByte, tracker.last_acked, 8'd0, AnswerLength, 1'b1);
    tick();
    start_op(OP_READ, 8'h7F);
    tick();
    drain();

    while (items_sent < RandomItems) random_phase();

    if (tracker.mismatches == 0 && tracker.expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
